[sv/nkx_pkg.sv]
// shared constants and types for the nucleotide k-mer extractor
package nkx_pkg;

  localparam int unsigned MaxSequence = 65536;
  localparam int unsigned MaxK        = 32;

  localparam int unsigned CharW  = 8;
  localparam int unsigned KW     = 6;
  localparam int unsigned CodeW  = 2;
  localparam int unsigned KmerW  = CodeW * MaxK;
  localparam int unsigned PosW   = 16;
  localparam int unsigned CntW   = $clog2(MaxSequence + 1);
  localparam int unsigned LaneW  = $clog2(MaxK);

  localparam logic [KW-1:0]   KmerLenReset = KW'(8);
  localparam logic [PosW-1:0] PosMax       = '1;

  localparam logic [CharW-1:0] ChA = 8'h41;
  localparam logic [CharW-1:0] ChT = 8'h54;
  localparam logic [CharW-1:0] ChC = 8'h43;
  localparam logic [CharW-1:0] ChG = 8'h47;

  localparam logic [CodeW-1:0] CodeA = 2'h0;
  localparam logic [CodeW-1:0] CodeT = 2'h1;
  localparam logic [CodeW-1:0] CodeC = 2'h2;
  localparam logic [CodeW-1:0] CodeG = 2'h3;

  typedef enum logic [1:0] {
    ST_KMER     = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_e;

  // control handed to every cell of the window chain
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

[sv/nkx_char_if.sv]
// input channel: one ascii character per word
interface nkx_char_if;
  logic                        valid;
  logic                        ready;
  logic [nkx_pkg::CharW-1:0]   character;
  logic                        first;

  modport source (output valid, output character, output first, input ready);
  modport sink   (input valid, input character, input first, output ready);
endinterface

[sv/nkx_kmer_if.sv]
// output channel: one packed k-mer or error per word
interface nkx_kmer_if;
  logic                        valid;
  logic                        ready;
  logic [nkx_pkg::KmerW-1:0]   kmer;
  logic [nkx_pkg::PosW-1:0]    start_position;
  nkx_pkg::status_e            status;

  modport source (output valid, output kmer, output start_position, output status,
                  input ready);
  modport sink   (input valid, input kmer, input start_position, input status,
                  output ready);
endinterface

[sv/nkx_cell.sv]
// one window cell: holds a two-bit base code and takes its newer neighbour's on a shift
module nkx_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nkx_pkg::cell_ctl_t         ctl_i,
  input  logic [nkx_pkg::CodeW-1:0]  nb_i,
  output logic [nkx_pkg::CodeW-1:0]  code_o
);

  logic [nkx_pkg::CodeW-1:0] code_q, code_d;

  always_comb begin
    code_d = code_q;
    if (ctl_i.shift) begin
      code_d = ctl_i.clear ? '0 : nb_i;
    end else if (ctl_i.clear) begin
      code_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else begin
      code_q <= code_d;
    end
  end

  assign code_o = code_q;

endmodule

[sv/nucleotide_kmer_extractor_unit.sv]
// top level of the nucleotide k-mer extractor
// Takes one ASCII base per word and answers at most one word per base, one base a cycle
// sustained: the window is a chain of 32 two-bit cells that all shift in the same cycle,
// and the result register accepts a new base whenever its word is taken in that cycle.
// A base's result is registered and shown in the next cycle. kmer_length (clamped to
// 1..32) may only be written while nothing is in flight; a first flag restarts the
// window, the position count and the error lock. No clearing pass is needed after reset.
module nucleotide_kmer_extractor_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [nkx_pkg::KW-1:0]   cfg_wdata_i,
  nkx_char_if.sink                 char_i,
  nkx_kmer_if.source               kmer_o
);

  localparam int unsigned MaxK  = nkx_pkg::MaxK;
  localparam int unsigned CodeW = nkx_pkg::CodeW;
  localparam int unsigned CntW  = nkx_pkg::CntW;
  localparam int unsigned KW    = nkx_pkg::KW;
  localparam int unsigned PosW  = nkx_pkg::PosW;

  logic [KW-1:0]    klen_q;
  logic [CntW-1:0]  bases_q, bases_d, bases_eff, count;
  logic             failed_q, failed_d, failed_eff;
  logic             out_valid_q, out_valid_d;
  logic [PosW-1:0]  pos_q, pos_d;
  nkx_pkg::status_e status_q, status_d;

  logic             in_acc;
  logic             code_ok;
  logic [CodeW-1:0] code;
  logic             too_long;
  logic             shift;
  logic [KW-1:0]    k_eff;

  nkx_pkg::cell_ctl_t           ctl_old, ctl_new;
  logic [CodeW-1:0]             win [MaxK];
  logic [nkx_pkg::KmerW-1:0]    kmer_sel;

  function automatic logic [PosW-1:0] sat_pos(input logic [CntW-1:0] v);
    if (32'(v) > 32'(nkx_pkg::PosMax)) begin
      sat_pos = nkx_pkg::PosMax;
    end else begin
      sat_pos = PosW'(v);
    end
  endfunction

  assign char_i.ready = !out_valid_q || kmer_o.ready;
  assign in_acc       = char_i.valid && char_i.ready;

  // character decode
  always_comb begin
    code_ok = 1'b1;
    code    = nkx_pkg::CodeA;
    unique case (char_i.character)
      nkx_pkg::ChA: code = nkx_pkg::CodeA;
      nkx_pkg::ChT: code = nkx_pkg::CodeT;
      nkx_pkg::ChC: code = nkx_pkg::CodeC;
      nkx_pkg::ChG: code = nkx_pkg::CodeG;
      default: begin
        code_ok = 1'b0;
        code    = nkx_pkg::CodeA;
      end
    endcase
  end

  always_comb begin
    if (klen_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(klen_q) > MaxK) begin
      k_eff = KW'(MaxK);
    end else begin
      k_eff = klen_q;
    end
  end

  assign bases_eff  = char_i.first ? '0 : bases_q;
  assign failed_eff = char_i.first ? 1'b0 : failed_q;
  assign too_long   = 32'(bases_eff) >= nkx_pkg::MaxSequence;
  assign shift      = in_acc && !failed_eff && code_ok && !too_long;
  assign count      = bases_eff + CntW'(1);

  always_comb begin
    bases_d     = bases_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q && !kmer_o.ready;
    pos_d       = pos_q;
    status_d    = status_q;
    if (in_acc) begin
      bases_d  = bases_eff;
      failed_d = failed_eff;
      if (!failed_eff) begin
        if (!code_ok) begin
          out_valid_d = 1'b1;
          pos_d       = sat_pos(bases_eff);
          status_d    = nkx_pkg::ST_INVALID;
          failed_d    = 1'b1;
        end else if (too_long) begin
          out_valid_d = 1'b1;
          pos_d       = nkx_pkg::PosMax;
          status_d    = nkx_pkg::ST_TOO_LONG;
          failed_d    = 1'b1;
        end else begin
          bases_d = count;
          if (count >= CntW'(k_eff)) begin
            out_valid_d = 1'b1;
            pos_d       = sat_pos(count - CntW'(k_eff));
            status_d    = nkx_pkg::ST_KMER;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q      <= nkx_pkg::KmerLenReset;
      bases_q     <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      status_q    <= nkx_pkg::ST_KMER;
    end else begin
      if (cfg_we_i) begin
        klen_q <= cfg_wdata_i;
      end
      bases_q     <= bases_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      status_q    <= status_d;
    end
  end

  // window chain, cell MaxK-1 holds the newest base
  assign ctl_old.shift = shift;
  assign ctl_old.clear = in_acc && char_i.first;
  assign ctl_new.shift = shift;
  assign ctl_new.clear = in_acc && char_i.first && !shift;

  for (genvar i = 0; i < MaxK; i++) begin : g_cell
    if (i == MaxK - 1) begin : g_newest
      nkx_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl_new),
        .nb_i   (code),
        .code_o (win[i])
      );
    end else begin : g_older
      nkx_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl_old),
        .nb_i   (win[i+1]),
        .code_o (win[i])
      );
    end
  end

  // the window only moves when the pending word is taken, so read it straight from the cells
  always_comb begin
    logic [KW-1:0] idx;
    for (int j = 0; j < MaxK; j++) begin
      idx = KW'(MaxK) - k_eff + KW'(j);
      if (KW'(j) < k_eff) begin
        kmer_sel[CodeW*j +: CodeW] = win[idx[nkx_pkg::LaneW-1:0]];
      end else begin
        kmer_sel[CodeW*j +: CodeW] = '0;
      end
    end
  end

  assign kmer_o.valid          = out_valid_q;
  assign kmer_o.kmer           = (status_q == nkx_pkg::ST_KMER) ? kmer_sel : '0;
  assign kmer_o.start_position = pos_q;
  assign kmer_o.status         = status_q;

  // a locked sequence ignores bases without a first flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && failed_q && !char_i.first) |=> ($stable(bases_q) && failed_q))
    else $error("locked sequence changed state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bases_q) <= nkx_pkg::MaxSequence)
    else $error("base count ran past the limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !failed_eff && code_ok && too_long) |=>
      (out_valid_q && status_q == nkx_pkg::ST_TOO_LONG && failed_q))
    else $error("over-long sequence not reported");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kmer_o.valid && kmer_o.status == nkx_pkg::ST_KMER) |->
      ((kmer_o.kmer >> {k_eff, 1'b0}) == '0))
    else $error("k-mer has bits above its length");

endmodule
